@@ rtl/ll1p_pkg.sv @@
package ll1p_pkg;

    localparam int STACK_DEPTH_DEF = 256;

    localparam int SYM_W     = 4;
    localparam int STATUS_W  = 3;
    localparam int DEPTH_W   = 9;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;
    localparam int RULE_MAX  = 4;

    // terminals share their codes with the token codes
    typedef enum logic [SYM_W-1:0] {
        SYM_ID      = 4'd0,
        SYM_PRINT   = 4'd1,
        SYM_END     = 4'd2,
        SYM_ASSIGN  = 4'd3,
        SYM_LBRACE  = 4'd4,
        SYM_RBRACE  = 4'd5,
        SYM_NUMBER  = 4'd6,
        SYM_RANGE   = 4'd7,
        SYM_COMMA   = 4'd8,
        SYM_SEMI    = 4'd9,
        SYM_PROGRAM = 4'd10,
        SYM_PTAIL   = 4'd11,
        SYM_STMT    = 4'd12,
        SYM_SET     = 4'd13,
        SYM_LIST    = 4'd14,
        SYM_LTAIL   = 4'd15
    } sym_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_ACCEPT   = 3'd1,
        ST_SYNTAX   = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_DONE     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        PH_RUN    = 2'd0,
        PH_ACCEPT = 2'd1,
        PH_FAIL   = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        R_PROG, R_ASG, R_PRT, R_BRACE, R_RANGE, R_ID, R_LIST, R_LTAIL
    } rule_t;

    typedef enum logic [1:0] {
        ACT_EXPAND, ACT_POP, ACT_MATCH, ACT_ERROR
    } act_t;

    typedef struct packed {
        act_t  act;
        rule_t rule;
    } pred_t;

    // right-hand sides in push order, last pushed ends up on top
    localparam sym_t RULE_ROM [8][RULE_MAX] = '{
        '{SYM_PTAIL,  SYM_STMT,   SYM_ID,     SYM_ID},
        '{SYM_SEMI,   SYM_SET,    SYM_ASSIGN, SYM_ID},
        '{SYM_SEMI,   SYM_SET,    SYM_PRINT,  SYM_ID},
        '{SYM_RBRACE, SYM_LIST,   SYM_LBRACE, SYM_ID},
        '{SYM_NUMBER, SYM_RANGE,  SYM_NUMBER, SYM_ID},
        '{SYM_ID,     SYM_ID,     SYM_ID,     SYM_ID},
        '{SYM_LTAIL,  SYM_NUMBER, SYM_ID,     SYM_ID},
        '{SYM_LTAIL,  SYM_NUMBER, SYM_COMMA,  SYM_ID}
    };

    localparam logic [2:0] RULE_LEN [8] = '{
        3'd2, 3'd4, 3'd3, 3'd3, 3'd3, 3'd1, 3'd2, 3'd3
    };

    // ll(1) prediction table
    function automatic pred_t predict(sym_t top, sym_t tok);
        pred_t p;
        p.act  = ACT_ERROR;
        p.rule = R_PROG;
        unique case (top) inside
            SYM_PROGRAM, SYM_PTAIL: begin
                if (tok == SYM_ID || tok == SYM_PRINT) begin
                    p.act  = ACT_EXPAND;
                    p.rule = R_PROG;
                end else if (top == SYM_PTAIL && tok == SYM_END) begin
                    p.act = ACT_POP;
                end
            end
            SYM_STMT: begin
                if (tok == SYM_ID) begin
                    p.act  = ACT_EXPAND;
                    p.rule = R_ASG;
                end else if (tok == SYM_PRINT) begin
                    p.act  = ACT_EXPAND;
                    p.rule = R_PRT;
                end
            end
            SYM_SET: begin
                if (tok == SYM_LBRACE) begin
                    p.act  = ACT_EXPAND;
                    p.rule = R_BRACE;
                end else if (tok == SYM_NUMBER) begin
                    p.act  = ACT_EXPAND;
                    p.rule = R_RANGE;
                end else if (tok == SYM_ID) begin
                    p.act  = ACT_EXPAND;
                    p.rule = R_ID;
                end
            end
            SYM_LIST: begin
                if (tok == SYM_NUMBER) begin
                    p.act  = ACT_EXPAND;
                    p.rule = R_LIST;
                end
            end
            SYM_LTAIL: begin
                if (tok == SYM_COMMA) begin
                    p.act  = ACT_EXPAND;
                    p.rule = R_LTAIL;
                end else if (tok == SYM_RBRACE) begin
                    p.act = ACT_POP;
                end
            end
            default: begin
                if (top == tok) begin
                    p.act = ACT_MATCH;
                end
            end
        endcase
        return p;
    endfunction

    // microcode
    typedef enum logic [2:0] {
        OP_LOAD, OP_CHECK, OP_READ, OP_DECODE, OP_PUSH, OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        SEQ_NEXT, SEQ_WAIT_IN, SEQ_DISPATCH, SEQ_LOOP, SEQ_WAIT_OUT
    } seq_t;

    typedef enum logic [2:0] {
        U_IDLE, U_CHECK, U_FETCH, U_DECODE, U_PUSH, U_EMIT
    } step_t;

    typedef struct packed {
        op_t   op;
        seq_t  seq;
        step_t target;
        step_t alt;
    } uword_t;

    function automatic uword_t ucode(step_t s);
        uword_t w;
        unique case (s)
            U_IDLE:   w = '{op: OP_LOAD,   seq: SEQ_WAIT_IN,  target: U_CHECK,  alt: U_IDLE};
            U_CHECK:  w = '{op: OP_CHECK,  seq: SEQ_NEXT,     target: U_FETCH,  alt: U_FETCH};
            U_FETCH:  w = '{op: OP_READ,   seq: SEQ_NEXT,     target: U_DECODE, alt: U_DECODE};
            U_DECODE: w = '{op: OP_DECODE, seq: SEQ_DISPATCH, target: U_PUSH,   alt: U_FETCH};
            U_PUSH:   w = '{op: OP_PUSH,   seq: SEQ_LOOP,     target: U_FETCH,  alt: U_PUSH};
            U_EMIT:   w = '{op: OP_EMIT,   seq: SEQ_WAIT_OUT, target: U_IDLE,   alt: U_EMIT};
            default:  w = '{op: OP_LOAD,   seq: SEQ_NEXT,     target: U_IDLE,   alt: U_IDLE};
        endcase
        return w;
    endfunction

endpackage

@@ rtl/ll1p_stack.sv @@
module ll1p_stack #(
    parameter int DEPTH = ll1p_pkg::STACK_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [ll1p_pkg::SYM_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [ll1p_pkg::SYM_W-1:0] rd_data
);
    import ll1p_pkg::*;

    logic [SYM_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/ll1_set_grammar_parser_core.sv @@
// ll(1) recognizer for a small set-assignment language, one token per transaction.
// input channel s_*: tdata[3:0] token code, tdata[4] restart (reload the start
// symbol before this token). result channel m_*: tdata[2:0] status, tdata[11:3]
// low 9 bits of the stack depth after the token; one result per token.
// a microcode sequencer walks each token through check, fetch top, decode and
// push steps against a symbol stack in block memory with separate read and write ports.
// per token, the steps run check, fetch, decode and emit; each top-of-stack
// pop without consuming adds another fetch and decode, and each expansion adds
// one push step per symbol (up to 4 symbols) before the next fetch and decode;
// a token is accepted in the cycle after the result of the last one is loaded,
// so a new token is not taken before the last one has reached the emit step.
// the finished result waits in an output register, so the next token is
// taken while the receiver stalls; processing of that token then stops at
// the result step until the register is taken.
// reset: stack holds the start symbol, depth 1, parser running; entry 0 of
// the stack memory is written with the start symbol on the first token.
module ll1_set_grammar_parser_core #(
    parameter int STACK_DEPTH = ll1p_pkg::STACK_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ll1p_pkg::S_TDATA_W-1:0] s_tdata,   // token[3:0], restart[4]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ll1p_pkg::M_TDATA_W-1:0] m_tdata    // status[2:0], stack_depth[11:3]
);
    import ll1p_pkg::*;

    localparam int SPW   = $clog2(STACK_DEPTH + 1);
    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int M_PAD = M_TDATA_W - DEPTH_W - STATUS_W;
    localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);
    localparam logic [SPW-1:0] SP_ONE  = SPW'(1);

    step_t              step_reg, step_next;
    sym_t               tok_reg, tok_next;
    logic [SPW-1:0]     sp_reg, sp_next;
    phase_t             phase_reg, phase_next;
    logic               init_reg, init_next;
    rule_t              rule_reg, rule_next;
    logic [1:0]         idx_reg, idx_next;
    status_t            status_reg, status_next;
    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg, out_status_next;
    logic [DEPTH_W-1:0] out_depth_reg, out_depth_next;

    uword_t           uw;
    logic             in_fire, out_free, fin, last_push;
    logic [SPW-1:0]   sp_dec;
    pred_t            pred;
    logic             wr_en, rd_en;
    logic [AW-1:0]    wr_addr, rd_addr;
    sym_t             wr_data;
    logic [SYM_W-1:0] rd_data;

    assign uw        = ucode(step_reg);
    assign s_tready  = (uw.seq == SEQ_WAIT_IN);
    assign in_fire   = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign sp_dec    = sp_reg - SP_ONE;
    assign pred      = predict(sym_t'(rd_data), tok_reg);
    assign last_push = ((3'({1'b0, idx_reg}) + 3'd1) == RULE_LEN[rule_reg]);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{M_PAD{1'b0}}, out_depth_reg, out_status_reg};

    ll1p_stack #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // sequencer
    always_comb begin
        step_next = step_reg;
        unique case (uw.seq)
            SEQ_WAIT_IN:  step_next = in_fire ? uw.target : uw.alt;
            SEQ_NEXT:     step_next = uw.target;
            SEQ_DISPATCH: step_next = (pred.act == ACT_EXPAND) ? uw.target : uw.alt;
            SEQ_LOOP:     step_next = last_push ? uw.target : uw.alt;
            SEQ_WAIT_OUT: step_next = out_free ? uw.target : uw.alt;
            default:      step_next = U_IDLE;
        endcase
        // any step that settles the status ends the token
        if (fin) begin
            step_next = U_EMIT;
        end
    end

    // datapath control
    always_comb begin
        tok_next        = tok_reg;
        sp_next         = sp_reg;
        phase_next      = phase_reg;
        init_next       = init_reg;
        rule_next       = rule_reg;
        idx_next        = idx_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_depth_next  = out_depth_reg;
        fin             = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = SYM_PROGRAM;
        rd_en           = 1'b0;
        rd_addr         = AW'(sp_dec);
        unique case (uw.op)
            OP_LOAD: begin
                if (in_fire) begin
                    tok_next = sym_t'(s_tdata[SYM_W-1:0]);
                    if (s_tdata[SYM_W] || init_reg) begin
                        sp_next    = SP_ONE;
                        phase_next = PH_RUN;
                        init_next  = 1'b0;
                        wr_en      = 1'b1;
                    end
                end
            end
            OP_CHECK: begin
                if (phase_reg != PH_RUN) begin
                    fin         = 1'b1;
                    status_next = ST_DONE;
                end else if (tok_reg > SYM_SEMI) begin
                    fin         = 1'b1;
                    status_next = ST_SYNTAX;
                    phase_next  = PH_FAIL;
                end
            end
            OP_READ: begin
                if (sp_reg == '0) begin
                    fin         = 1'b1;
                    status_next = ST_SYNTAX;
                    phase_next  = PH_FAIL;
                end else begin
                    rd_en = 1'b1;
                end
            end
            OP_DECODE: begin
                unique case (pred.act)
                    ACT_MATCH: begin
                        sp_next     = sp_dec;
                        fin         = 1'b1;
                        status_next = ST_OK;
                    end
                    ACT_POP: begin
                        sp_next = sp_dec;
                        if (sym_t'(rd_data) == SYM_PTAIL && sp_dec == '0) begin
                            fin         = 1'b1;
                            status_next = ST_ACCEPT;
                            phase_next  = PH_ACCEPT;
                        end
                    end
                    ACT_EXPAND: begin
                        sp_next   = sp_dec;
                        rule_next = pred.rule;
                        idx_next  = 2'd0;
                    end
                    default: begin
                        fin         = 1'b1;
                        status_next = ST_SYNTAX;
                        phase_next  = PH_FAIL;
                    end
                endcase
            end
            OP_PUSH: begin
                if (sp_reg >= SP_FULL) begin
                    fin         = 1'b1;
                    status_next = ST_OVERFLOW;
                    phase_next  = PH_FAIL;
                end else begin
                    wr_en    = 1'b1;
                    wr_addr  = AW'(sp_reg);
                    wr_data  = RULE_ROM[rule_reg][idx_reg];
                    sp_next  = sp_reg + SP_ONE;
                    idx_next = idx_reg + 2'd1;
                end
            end
            OP_EMIT: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_depth_next  = DEPTH_W'(sp_reg);
                end
            end
            default: begin
                fin = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= U_IDLE;
            sp_reg        <= SP_ONE;
            phase_reg     <= PH_RUN;
            init_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            step_reg      <= step_next;
            sp_reg        <= sp_next;
            phase_reg     <= phase_next;
            init_reg      <= init_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tok_reg        <= tok_next;
        rule_reg       <= rule_next;
        idx_reg        <= idx_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_depth_reg  <= out_depth_next;
    end

`ifndef SYNTHESIS
    a_sp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SP_FULL)
        else $error("stack pointer beyond stack depth");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && uw.op == OP_PUSH) |-> sp_reg < SP_FULL)
        else $error("push into a full stack");

    a_accept_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (uw.op == OP_EMIT && status_reg == ST_ACCEPT) |-> sp_reg == '0)
        else $error("accept reported with symbols left");

    a_done_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (uw.op == OP_EMIT && status_reg == ST_DONE) |-> phase_reg != PH_RUN)
        else $error("finished status while parser running");

    a_in_check: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> step_reg == U_CHECK)
        else $error("accepted transaction not checked next");
`endif

endmodule
